>>> rtl/hamming_code_encoder_macros.svh
// assertion macros for the hamming code encoder checker
// used by hce_checker.sv, needs i_clk and i_rst_n in scope
`ifndef HAMMING_CODE_ENCODER_MACROS_SVH
`define HAMMING_CODE_ENCODER_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define HCE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hce assertion failed");

// next-cycle implication, quiet while reset is held
`define HCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hce assertion failed");

// next-cycle implication that also holds across reset
`define HCE_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("hce reset assertion failed");

`endif

>>> rtl/hce_pkg.sv
// shared constants and elaboration-time functions for the hamming code encoder
// no dependencies
`timescale 1ns / 1ps

package hce_pkg;

    localparam int MAX_DATA_BITS_C = 57;
    localparam int CFG_W           = 6;
    localparam logic [CFG_W-1:0] DATA_LENGTH_RST = CFG_W'(4);

    // least r with 2^r >= m + r + 1
    function automatic int f_parity_count(input int m);
        int r;
        r = 0;
        while ((1 << r) < m + r + 1) r++;
        return r;
    endfunction

    function automatic int f_code_width(input int m);
        return m + f_parity_count(m);
    endfunction

    // 1-based codeword position of data bit j
    function automatic int f_code_pos(input int j);
        int pos;
        int cnt;
        pos = 0;
        cnt = -1;
        while (cnt < j) begin
            pos++;
            if ((pos & (pos - 1)) != 0) cnt++;
        end
        return pos;
    endfunction

    // data bits covered by parity position 2^k
    function automatic logic [MAX_DATA_BITS_C-1:0] f_parity_mask(input int k);
        logic [MAX_DATA_BITS_C-1:0] mask;
        mask = '0;
        for (int j = 0; j < MAX_DATA_BITS_C; j++) begin
            if (((f_code_pos(j) >> k) & 1) != 0) mask[j] = 1'b1;
        end
        return mask;
    endfunction

endpackage

>>> rtl/hamming_code_encoder.sv
// Hamming code encoder, even parity, configurable data length.
// Input channel: i_in_valid / o_in_stall carry i_data_bits; a transaction
//   happens at a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry o_codeword and
//   o_code_length; one result transaction per input transaction, in order.
// Config: i_cfg_we writes i_cfg_wdata into data_length (reset 4); write it
//   only while the block is empty. Zero acts as one, values above the
//   maximum act as the maximum.
// Datapath: input register, xor network, result register.
// Throughput: one word per cycle unless the output stalls; the two
//   register stages each advance when empty or their contents leave.
// Stall: a stalled result holds its payload; the input register keeps
//   accepting; o_in_stall rises when both stages are full and stalled.
// Reset: synchronous active-low, empties both stages and restores
//   data_length to 4.
// depends on hce_pkg, hce_stage, hce_encode
`timescale 1ns / 1ps

module hamming_code_encoder #(
    parameter  int P_MAX_DATA_BITS = hce_pkg::MAX_DATA_BITS_C,
    localparam int CW    = hce_pkg::f_code_width(P_MAX_DATA_BITS),
    localparam int LEN_W = $clog2(CW + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [hce_pkg::CFG_W-1:0]    i_cfg_wdata,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [P_MAX_DATA_BITS-1:0]   i_data_bits,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [CW-1:0]                o_codeword,
    output logic [LEN_W-1:0]             o_code_length
);

    import hce_pkg::*;

    localparam int S1_W = P_MAX_DATA_BITS + CFG_W;
    localparam int S2_W = CW + LEN_W;

    logic [CFG_W-1:0]           r_data_length;
    // stage one: captured word plus the length in force when it arrived
    logic                       s1_valid;
    logic                       s1_stall;
    logic [S1_W-1:0]            s1_data;
    logic [P_MAX_DATA_BITS-1:0] s1_word;
    logic [CFG_W-1:0]           s1_length;
    // encoder output feeding the result register
    logic [CW-1:0]              enc_code;
    logic [LEN_W-1:0]           enc_len;
    logic [S2_W-1:0]            s2_data;

    // config register, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= DATA_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_data_length <= i_cfg_wdata;
        end
    end

    hce_stage #(
        .P_WIDTH (S1_W)
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  ({i_data_bits, r_data_length}),
        .o_valid (s1_valid),
        .i_stall (s1_stall),
        .o_data  (s1_data)
    );

    assign s1_word   = s1_data[S1_W-1:CFG_W];
    assign s1_length = s1_data[CFG_W-1:0];

    // scatter and parity trees between the two registers
    hce_encode #(
        .P_MAX_DATA_BITS (P_MAX_DATA_BITS)
    ) u_encode (
        .i_data        (s1_word),
        .i_length      (s1_length),
        .o_codeword    (enc_code),
        .o_code_length (enc_len)
    );

    hce_stage #(
        .P_WIDTH (S2_W)
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_stall (s1_stall),
        .i_data  ({enc_code, enc_len}),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (s2_data)
    );

    assign o_codeword    = s2_data[S2_W-1:LEN_W];
    assign o_code_length = s2_data[LEN_W-1:0];

endmodule

>>> rtl/hce_stage.sv
// one valid/stall register stage with a registered payload
// depends on nothing
`timescale 1ns / 1ps

module hce_stage #(
    parameter int P_WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [P_WIDTH-1:0] i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [P_WIDTH-1:0] o_data
);

    logic               r_valid;
    logic [P_WIDTH-1:0] r_data;
    logic               load_en;

    // stage frees up when empty or when its contents leave this cycle
    assign load_en = !r_valid || !i_stall;
    assign o_stall = !load_en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

>>> rtl/hce_encode.sv
// combinational hamming encode: length clamp, data scatter, parity xor trees
// depends on hce_pkg
`timescale 1ns / 1ps

module hce_encode #(
    parameter  int P_MAX_DATA_BITS = hce_pkg::MAX_DATA_BITS_C,
    localparam int CW    = hce_pkg::f_code_width(P_MAX_DATA_BITS),
    localparam int LEN_W = $clog2(CW + 1)
) (
    input  logic [P_MAX_DATA_BITS-1:0]   i_data,
    input  logic [hce_pkg::CFG_W-1:0]    i_length,
    output logic [CW-1:0]                o_codeword,
    output logic [LEN_W-1:0]             o_code_length
);

    import hce_pkg::*;

    localparam int R_MAX = f_parity_count(P_MAX_DATA_BITS);

    logic [CFG_W-1:0]           m_eff;
    logic [P_MAX_DATA_BITS-1:0] data_m;
    logic [LEN_W-1:0]           par_cnt;

    // zero length acts as one, over-long acts as the maximum
    always_comb begin
        if (i_length == '0) begin
            m_eff = CFG_W'(1);
        end else if (i_length > CFG_W'(P_MAX_DATA_BITS)) begin
            m_eff = CFG_W'(P_MAX_DATA_BITS);
        end else begin
            m_eff = i_length;
        end
    end

    for (genvar j = 0; j < P_MAX_DATA_BITS; j++) begin : g_mask
        assign data_m[j] = i_data[j] && (CFG_W'(j) < m_eff);
    end

    // independent compares, the count of failed thresholds is r
    always_comb begin
        par_cnt = '0;
        for (int k = 0; k < R_MAX; k++) begin
            if ((CFG_W + 1)'(1 << k) < ({1'b0, m_eff} + (CFG_W + 1)'(k + 1))) begin
                par_cnt = LEN_W'(k + 1);
            end
        end
    end

    assign o_code_length = LEN_W'(m_eff) + par_cnt;

    for (genvar j = 0; j < P_MAX_DATA_BITS; j++) begin : g_scatter
        assign o_codeword[f_code_pos(j) - 1] = data_m[j];
    end

    for (genvar k = 0; k < R_MAX; k++) begin : g_parity
        localparam logic [MAX_DATA_BITS_C-1:0] PMASK = f_parity_mask(k);
        assign o_codeword[(1 << k) - 1] = ^(data_m & PMASK[P_MAX_DATA_BITS-1:0]);
    end

endmodule

>>> rtl/hce_checker.sv
// port-level assertions for the hamming code encoder, bound to the top level
// depends on hce_pkg and hamming_code_encoder_macros.svh
`timescale 1ns / 1ps
`include "hamming_code_encoder_macros.svh"

module hce_checker #(
    parameter  int P_MAX_DATA_BITS = hce_pkg::MAX_DATA_BITS_C,
    localparam int CW    = hce_pkg::f_code_width(P_MAX_DATA_BITS),
    localparam int LEN_W = $clog2(CW + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_in_stall,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic [CW-1:0]                o_codeword,
    input  logic [LEN_W-1:0]             o_code_length
);

    // stalled result holds
    `HCE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_codeword) && $stable(o_code_length))

    // no codeword bit at or above the reported length
    `HCE_ASSERT_NOW(a_code_bound, o_out_valid, (o_codeword >> o_code_length) == '0)

    // input side only backs up when both stages are full and the sink stalls
    `HCE_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // reset empties the pipeline
    `HCE_ASSERT_RST(a_rst_empty, !i_rst_n, !o_out_valid)

endmodule

bind hamming_code_encoder hce_checker #(
    .P_MAX_DATA_BITS (P_MAX_DATA_BITS)
) u_hce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_codeword    (o_codeword),
    .o_code_length (o_code_length)
);

>>> sim/tb_hamming_code_encoder.sv
// self-checking testbench for the hamming code encoder
// depends on hce_pkg and the hamming_code_encoder rtl, nothing else
`timescale 1ns / 1ps

module tb_hamming_code_encoder;

    localparam int DATA_W  = hce_pkg::MAX_DATA_BITS_C;
    localparam int CFG_W   = hce_pkg::CFG_W;
    localparam int CODE_W  = 63;
    localparam int LEN_W   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 6;    // a margin over the two-stage pipeline
    localparam int HOLD_CYCLES   = 60;   // long receiver hold-off
    localparam int PHASE_ITEMS   = 50;
    localparam int NUM_PHASES    = 15;
    localparam int CYCLE_LIMIT   = 200000;

    // idling profiles, percent of cycles
    localparam int IDLE_NONE = 0;
    localparam int IDLE_HIGH = 56;
    localparam int IDLE_BOTH = 36;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [DATA_W-1:0]   in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CODE_W-1:0]   out_codeword;
    logic [LEN_W-1:0]    out_code_length;

    hamming_code_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_data_bits   (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_codeword    (out_codeword),
        .o_code_length (out_code_length)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    typedef struct packed {
        logic [CODE_W-1:0] codeword;
        logic [LEN_W-1:0]  code_length;
    } code_result_t;

    // one directed row: optional register write, the data word, and a
    // typed-in result where it is obvious by inspection
    typedef struct packed {
        logic              wr_len;
        logic [CFG_W-1:0]  len;
        logic [DATA_W-1:0] data;
        logic              typed;
        logic [CODE_W-1:0] codeword;
        logic [LEN_W-1:0]  code_length;
    } dir_row_t;

    localparam int NUM_DIR = 23;
    localparam logic [DATA_W-1:0] ONES57 = {DATA_W{1'b1}};
    localparam logic [CODE_W-1:0] ONES63 = {CODE_W{1'b1}};

    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        // reset length of 4: 7-bit codewords
        '{1'b0, 6'd4,  57'h0,                 1'b1, 63'h0,  6'd7},
        '{1'b0, 6'd4,  57'hf,                 1'b1, 63'h7f, 6'd7},
        '{1'b0, 6'd4,  ONES57,                1'b1, 63'h7f, 6'd7},
        // bits above the length are ignored
        '{1'b0, 6'd4,  57'h1ff_ffff_ffff_fff0, 1'b1, 63'h0, 6'd7},
        '{1'b0, 6'd4,  57'h5,                 1'b0, 63'h0,  6'd0},
        // zero length acts as one
        '{1'b1, 6'd0,  57'h1,                 1'b1, 63'h7,  6'd3},
        '{1'b0, 6'd0,  57'h0,                 1'b1, 63'h0,  6'd3},
        '{1'b0, 6'd0,  ONES57,                1'b1, 63'h7,  6'd3},
        '{1'b1, 6'd1,  57'h1,                 1'b1, 63'h7,  6'd3},
        '{1'b0, 6'd1,  57'h2,                 1'b1, 63'h0,  6'd3},
        // full length, 63-bit codeword
        '{1'b1, 6'd57, 57'h0,                 1'b1, 63'h0,  6'd63},
        '{1'b0, 6'd57, ONES57,                1'b1, ONES63, 6'd63},
        '{1'b0, 6'd57, 57'h0aa_aaaa_aaaa_aaaa, 1'b0, 63'h0, 6'd0},
        '{1'b0, 6'd57, 57'h1,                 1'b0, 63'h0,  6'd0},
        '{1'b0, 6'd57, 57'h100_0000_0000_0000, 1'b0, 63'h0, 6'd0},
        // too long clamps to the maximum
        '{1'b1, 6'd63, ONES57,                1'b1, ONES63, 6'd63},
        '{1'b0, 6'd63, 57'h123_4567_89ab_cdef, 1'b0, 63'h0, 6'd0},
        '{1'b1, 6'd58, 57'h0,                 1'b1, 63'h0,  6'd63},
        // lengths 11 and 26 fill their codeword exactly; 2 and 42 leave it short
        '{1'b1, 6'd11, 57'h5a3,               1'b0, 63'h0,  6'd0},
        '{1'b0, 6'd11, ONES57,                1'b1, 63'h7fff, 6'd15},
        '{1'b1, 6'd26, ONES57,                1'b1, 63'h7fff_ffff, 6'd31},
        '{1'b1, 6'd2,  57'h3,                 1'b0, 63'h0,  6'd0},
        '{1'b1, 6'd42, 57'h1ab_cdef_0123_4567, 1'b0, 63'h0, 6'd0}
    };

    // testbench copy of data_length
    logic [CFG_W-1:0] model_len = hce_pkg::DATA_LENGTH_RST;

    code_result_t pending_codes [$];
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  send_idle_pct = IDLE_NONE;
    int unsigned  recv_stall_pct = IDLE_NONE;
    int unsigned  hold_reqs = 0;
    int unsigned  hold_done = 0;
    int unsigned  hold_left = 0;

    // encode one word the way the block should: clamp the length, pick
    // the parity count, scatter data bits, then fill parity positions
    function automatic code_result_t encode_word(input logic [CFG_W-1:0] len_reg,
                                                 input logic [DATA_W-1:0] data);
        code_result_t res;
        int m;
        int r;
        int j;
        int syn;
        m = int'(len_reg);
        if (m < 1) m = 1;
        if (m > DATA_W) m = DATA_W;
        r = 0;
        while ((1 << r) < m + r + 1) r++;
        res = '0;
        syn = 0;
        j = 0;
        for (int pos = 1; pos <= m + r; pos++) begin
            // skip power-of-two slots, they carry parity
            if ((pos & (pos - 1)) != 0) begin
                if (data[j]) begin
                    res.codeword[pos-1] = 1'b1;
                    syn ^= pos;
                end
                j++;
            end
        end
        for (int k = 0; k < r; k++) begin
            if (((syn >> k) & 1) != 0) res.codeword[(1 << k) - 1] = 1'b1;
        end
        res.code_length = LEN_W'(m + r);
        return res;
    endfunction

    // run-length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, pending_codes.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stall: random per profile, or a long counted hold-off
    // when the stimulus asks for one
    always @(posedge i_clk) begin
        if (hold_reqs != hold_done) begin
            hold_done = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // result checker: every output transaction against the oldest
    // expectation, field by field
    always @(posedge i_clk) begin
        code_result_t exp_res;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_codes.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h / %0d",
                         $time, out_codeword, out_code_length);
                error_count++;
            end else begin
                exp_res = pending_codes.pop_front();
                if (out_codeword !== exp_res.codeword) begin
                    $display("%0t codeword mismatch: expected %h actual %h",
                             $time, exp_res.codeword, out_codeword);
                    error_count++;
                end
                if (out_code_length !== exp_res.code_length) begin
                    $display("%0t code_length mismatch: expected %0d actual %0d",
                             $time, exp_res.code_length, out_code_length);
                    error_count++;
                end
            end
        end
    end

    // offer one word, with a random gap first; the expectation is queued
    // at the edge where the transaction happens
    task automatic send_word(input logic [DATA_W-1:0] data, input logic typed,
                             input code_result_t typed_res);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= data;
        do @(posedge i_clk); while (in_stall);
        if (typed) pending_codes.push_back(typed_res);
        else pending_codes.push_back(encode_word(model_len, data));
    endtask

    // let every result out, then let the pipeline settle
    task automatic wait_empty();
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, only called with the block empty
    task automatic write_len(input logic [CFG_W-1:0] value);
        in_valid  <= 1'b0;
        wait_empty();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        model_len = value;
    endtask

    function automatic logic [CFG_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd57;
            3: return 6'd63;
            4: return CFG_W'($urandom_range(58, 62));
            default: return CFG_W'($urandom_range(2, 56));
        endcase
    endfunction

    // mostly random words, some structured ones: zero, all ones, one bit set or clear within the length
    function automatic logic [DATA_W-1:0] pick_data(input logic [CFG_W-1:0] len_reg);
        int m;
        m = (len_reg < 1) ? 1 : ((len_reg > DATA_W) ? DATA_W : int'(len_reg));
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONES57;
            2: return DATA_W'(1) << $urandom_range(0, m - 1);
            3: return ~(DATA_W'(1) << $urandom_range(0, m - 1));
            default: return DATA_W'({$urandom(), $urandom()});
        endcase
    endfunction

    initial begin
        code_result_t typed_res;
        logic [CFG_W-1:0] len;
        int mode;

        // reset, held and then released
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling
        for (int i = 0; i < NUM_DIR; i++) begin
            if (DIR_ROWS[i].wr_len) write_len(DIR_ROWS[i].len);
            typed_res.codeword    = DIR_ROWS[i].codeword;
            typed_res.code_length = DIR_ROWS[i].code_length;
            send_word(DIR_ROWS[i].data, DIR_ROWS[i].typed, typed_res);
        end

        // random phases rotate through the idling profiles
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            len = (ph == 0) ? 6'd57 : ((ph == 1) ? 6'd0 : pick_len());
            write_len(len);
            mode = ph % 4;
            send_idle_pct  = (mode == 1) ? IDLE_HIGH : ((mode == 3) ? IDLE_BOTH : IDLE_NONE);
            recv_stall_pct = (mode == 2) ? IDLE_HIGH : ((mode == 3) ? IDLE_BOTH : IDLE_NONE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while words keep coming, so both
                // stages fill and the input stalls
                if ((ph == 4 || ph == 9) && n == 10) hold_reqs++;
                // sender pause until everything in flight is out
                if (ph == 6 && n == 25) begin
                    in_valid <= 1'b0;
                    wait_empty();
                end
                send_word(pick_data(model_len), 1'b0, typed_res);
            end
        end

        // drain and finish
        in_valid <= 1'b0;
        send_idle_pct  = IDLE_NONE;
        recv_stall_pct = IDLE_NONE;
        wait_empty();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> hamming_code_encoder.f
+incdir+rtl
rtl/hce_pkg.sv
rtl/hce_stage.sv
rtl/hce_encode.sv
rtl/hamming_code_encoder.sv
rtl/hce_checker.sv
sim/tb_hamming_code_encoder.sv
